@@ src/sha256_hash_engine_defines.svh @@
// assertion macros shared by the checker
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// plain implication check, reset gated
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check, reset gated
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sha_pkg.sv @@
package sha_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_DIGEST  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } item_t;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha_if.sv @@
interface sha_in_if;
  import sha_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha_queue.sv @@
module sha_queue
  import sha_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o
);
  item_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end
endmodule

@@ src/sha_front.sv @@
module sha_front
  import sha_pkg::*;
(
  sha_in_if.sink in_if,
  input  logic   q_full_i,
  output logic   push_o,
  output item_t  item_o
);
  // unused command is dropped here, never queued
  assign in_if.ready     = !q_full_i;
  assign item_o.command  = cmd_e'(in_if.command);
  assign item_o.data_byte = in_if.data_byte;
  assign push_o = in_if.valid && !q_full_i && (cmd_e'(in_if.command) != CMD_UNUSED);
endmodule

@@ src/sha_back.sv @@
module sha_back
  import sha_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_empty_i,
  input  item_t  item_i,
  output logic   pop_o,
  sha_out_if.source out_if
);
  state_e state_q, state_d;

  word_t       hash_q [8];
  word_t       blk_q  [16];
  logic [63:0] count_q;

  // working copy for compression
  word_t       w_q [16];
  word_t       v_q [8];
  word_t       hw_q [8];
  logic [5:0]  rnd_q;
  logic        dig_q;   // compressing for a digest
  logic        second_q; // digest needs a further block
  logic [2:0]  idx_q;

  logic [5:0] pos;
  logic [3:0] wi;
  assign pos = count_q[5:0];
  assign wi  = pos[5:2];

  word_t s0, s1, wnew, t1, t2;
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // padded first block of a digest
  word_t pad_blk [16];
  logic [63:0] bits;
  always_comb begin
    word_t wv;
    bits = {count_q[60:0], 3'b000};
    wv = {blk_q[wi][23:0], 8'h80};
    case (pos[1:0])
      2'd0: wv = {wv[7:0], 24'h0};
      2'd1: wv = {wv[15:0], 16'h0};
      2'd2: wv = {wv[23:0], 8'h0};
      default: wv = wv;
    endcase
    for (int k = 0; k < 16; k++) begin
      if (4'(k) < wi) pad_blk[k] = blk_q[k];
      else if (4'(k) == wi) pad_blk[k] = wv;
      else pad_blk[k] = '0;
    end
    if (wi < 4'd14) begin
      pad_blk[14] = bits[63:32];
      pad_blk[15] = bits[31:0];
    end
  end

  logic absorb_last;
  assign absorb_last = !q_empty_i && item_i.command == CMD_ABSORB && pos == 6'd63;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) begin
        if (item_i.command == CMD_DIGEST || absorb_last) state_d = ST_ROUND;
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (!dig_q) state_d = ST_IDLE;
        else if (second_q) state_d = ST_ROUND;
        else state_d = ST_EMIT;
      end
      ST_EMIT: if (out_if.ready && idx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    out_if.valid = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = !q_empty_i;
      ST_EMIT: out_if.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_if.digest_word = hw_q[idx_q];
  assign out_if.word_index  = idx_q;
  assign out_if.last_word   = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      dig_q   <= 1'b0;
      second_q <= 1'b0;
      for (int k = 0; k < 8; k++) hash_q[k] <= InitHash[k];
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (!q_empty_i) begin
          rnd_q <= '0;
          idx_q <= '0;
          case (item_i.command)
            CMD_ABSORB: begin
              count_q <= count_q + 64'd1;
              dig_q <= 1'b0;
              second_q <= 1'b0;
            end
            CMD_RESTART: begin
              count_q <= '0;
              for (int k = 0; k < 8; k++) hash_q[k] <= InitHash[k];
            end
            CMD_DIGEST: begin
              dig_q <= 1'b1;
              second_q <= (wi >= 4'd14);
            end
            default: ;
          endcase
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_ADD: begin
          if (!dig_q) begin
            for (int k = 0; k < 8; k++) hash_q[k] <= hash_q[k] + v_q[k];
          end
          second_q <= 1'b0;
        end
        ST_EMIT: if (out_if.ready) idx_q <= idx_q + 3'd1;
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !q_empty_i) begin
      if (item_i.command == CMD_ABSORB) begin
        blk_q[wi] <= {blk_q[wi][23:0], item_i.data_byte};
        if (pos == 6'd63) begin
          for (int k = 0; k < 15; k++) w_q[k] <= blk_q[k];
          w_q[15] <= {blk_q[15][23:0], item_i.data_byte};
        end
      end else if (item_i.command == CMD_DIGEST) begin
        for (int k = 0; k < 16; k++) w_q[k] <= pad_blk[k];
      end
      for (int k = 0; k < 8; k++) begin
        v_q[k]  <= hash_q[k];
        hw_q[k] <= hash_q[k];
      end
    end else if (state_q == ST_ROUND) begin
      for (int k = 0; k < 15; k++) w_q[k] <= w_q[k+1];
      w_q[15] <= wnew;
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end else if (state_q == ST_ADD && dig_q) begin
      for (int k = 0; k < 8; k++) begin
        hw_q[k] <= hw_q[k] + v_q[k];
        v_q[k]  <= hw_q[k] + v_q[k];
      end
      // second digest block: zeros and the bit length
      for (int k = 0; k < 14; k++) w_q[k] <= '0;
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end
  end
endmodule

@@ src/sha256_hash_engine.sv @@
// sha-256 engine fed one message byte per word
// input channel carries command and data_byte; absorb packs a byte, digest
// emits eight digest words, restart reloads the initial hash, command 3 is dropped
// output channel carries digest_word, word_index and last_word, word 0 first
// the front accepts a word whenever the four-entry queue has room, so the
// sender sees no stall while the back is busy unless the queue fills
// the back takes one queued word per cycle when idle; an absorb packs its byte,
// and a 64th byte also runs the 64 rounds and then the hash update
// a digest runs the rounds over one block, or two when the padding spills over,
// before the words appear, then one word per cycle while the receiver is ready
// the single round unit computes one round a cycle
// a receiver stall holds the current word; the back waits and the queue fills
// reset clears the queue, the byte count and loads the standard initial hash;
// block words hold no reset value and are always written before use
module sha256_hash_engine
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  logic  push, pop, full, empty;
  item_t push_item, pop_item;

  // classify and enqueue
  sha_front u_front (
    .in_if    (in_if),
    .q_full_i (full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decoupling queue
  sha_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  // compression and digest output
  sha_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .item_i    (pop_item),
    .pop_o     (pop),
    .out_if    (out_if)
  );
endmodule

@@ src/sha_checker.sv @@
`include "sha256_hash_engine_defines.svh"
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i,
  input logic [31:0] digest_word_i
);
  `SHA_ASSERT_IMP(last_at_seven, clk_i, rst_ni, out_valid_i,
    last_word_i == (word_index_i == 3'd7), "last_word mismatch")
  `SHA_ASSERT_NEXT(index_steps, clk_i, rst_ni,
    out_valid_i && out_ready_i && !last_word_i,
    out_valid_i && word_index_i == $past(word_index_i) + 3'd1, "digest words not consecutive")
  `SHA_ASSERT_NEXT(stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(digest_word_i) && $stable(word_index_i), "stalled word changed")
endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .word_index_i  (out_if.word_index),
  .last_word_i   (out_if.last_word),
  .digest_word_i (out_if.digest_word)
);

@@ verif/sha_tb_pkg.sv @@
`timescale 1ns / 100ps
package sha_tb_pkg;
  import sha_pkg::*;

  typedef struct {
    cmd_e       command;
    logic [7:0] data_byte;
  } msg_item_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;
endpackage

@@ verif/tb_sha256_hash_engine.sv @@
`timescale 1ns / 100ps
module tb_sha256_hash_engine;
  import sha_pkg::*;
  import sha_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_hash_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round constants and initial hash, own copy
  logic [31:0] k_tab [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };
  logic [31:0] iv_tab [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // predictor state
  logic [31:0] chain_h [8];
  logic [31:0] msg_blk [16];
  logic [63:0] msg_len;

  msg_item_t   pending_words[$];
  digest_out_t digest_expect[$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          stim_done = 1'b0;
  bit          in_fire = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression folded into h
  task automatic compress_block(inout logic [31:0] h [8], input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
         + ((e & f) ^ (~e & g)) + k_tab[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
  endtask

  // advance the predictor by one accepted word, queue any digest words
  task automatic predict_word(msg_item_t it);
    logic [31:0] h [8];
    logic [31:0] blk [16];
    logic [31:0] w;
    logic [63:0] bits;
    int          pos, wi;
    digest_out_t o;
    pos = int'(msg_len[5:0]);
    wi = pos >> 2;
    case (it.command)
      CMD_ABSORB: begin
        msg_blk[wi] = {msg_blk[wi][23:0], it.data_byte};
        msg_len++;
        if (pos == 63) compress_block(chain_h, msg_blk);
      end
      CMD_RESTART: begin
        chain_h = iv_tab;
        msg_len = '0;
      end
      CMD_DIGEST: begin
        h = chain_h;
        blk = msg_blk;
        bits = msg_len << 3;
        w = {blk[wi][23:0], 8'h80};
        for (int k = (pos & 3) + 1; k < 4; k++) w = w << 8;
        blk[wi] = w;
        for (int k = wi + 1; k < 16; k++) blk[k] = '0;
        if (wi >= 14) begin
          compress_block(h, blk);
          for (int k = 0; k < 16; k++) blk[k] = '0;
        end
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        compress_block(h, blk);
        for (int k = 0; k < 8; k++) begin
          o.digest_word = h[k];
          o.word_index = 3'(k);
          o.last_word = (k == 7);
          digest_expect.push_back(o);
        end
      end
      default: ; // unused command is dropped
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
  end

  // driver: present the next pending word at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        predict_word('{cmd_e'(in_ch.command), in_ch.data_byte});
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && !(in_ch.valid && !in_fire) &&
          $urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.command   <= pending_words[0].command;
        in_ch.data_byte <= pending_words[0].data_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check each accepted digest word against the oldest expectation
  always @(posedge clk_i) begin
    digest_out_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (digest_expect.size() == 0) begin
        report_mismatch("unexpected digest word", out_ch.digest_word, '0);
      end else begin
        exp_w = digest_expect.pop_front();
        if (out_ch.digest_word !== exp_w.digest_word)
          report_mismatch("digest_word", out_ch.digest_word, exp_w.digest_word);
        if (out_ch.word_index !== exp_w.word_index)
          report_mismatch("word_index", 32'(out_ch.word_index), 32'(exp_w.word_index));
        if (out_ch.last_word !== exp_w.last_word)
          report_mismatch("last_word", 32'(out_ch.last_word), 32'(exp_w.last_word));
      end
    end
  end

  task automatic push_word(cmd_e c, logic [7:0] b);
    pending_words.push_back('{c, b});
  endtask

  // wait until the driver has handed over every queued word
  task automatic drain_sender();
    while (pending_words.size() > 0) @(posedge clk_i);
  endtask

  // a random message with digests sprinkled in, mostly short
  task automatic push_random_message(int n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      push_word(CMD_ABSORB, 8'($urandom));
      if ($urandom_range(15) == 0) push_word(CMD_DIGEST, 8'($urandom));
    end
    push_word(CMD_DIGEST, 8'($urandom));
    case ($urandom_range(9))
      0: push_word(CMD_UNUSED, 8'($urandom));
      1, 2, 3: push_word(CMD_RESTART, 8'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    int pct_send [4] = '{0, 83, 0, 37};
    int pct_recv [4] = '{0, 0, 83, 37};
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ABSORB;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    chain_h = iv_tab;
    for (int k = 0; k < 16; k++) msg_blk[k] = '0;
    msg_len = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty message, one byte, extremes, ignored commands
    push_word(CMD_DIGEST, 8'hFF);
    push_word(CMD_ABSORB, 8'h00);
    push_word(CMD_DIGEST, 8'h00);
    push_word(CMD_ABSORB, 8'hFF);
    push_word(CMD_UNUSED, 8'hFF);
    push_word(CMD_DIGEST, 8'h55);
    push_word(CMD_RESTART, 8'hAA);
    push_word(CMD_ABSORB, 8'h61);
    push_word(CMD_ABSORB, 8'h62);
    push_word(CMD_ABSORB, 8'h63);
    push_word(CMD_DIGEST, 8'h00);
    push_word(CMD_RESTART, 8'h00);
    drain_sender();
    // hold off until all digest words are back
    while (digest_expect.size() > 0) @(posedge clk_i);

    // random phases, each with its own idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      // length field wrap needs a counter near 2^64; instead cover both pad
      // shapes via lengths around 55/56 and full blocks
      push_random_message(55 + ph);
      push_random_message($urandom_range(0, 20));
      push_random_message($urandom_range(40, 50));
      drain_sender();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_sender();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (digest_expect.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && digest_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
